FILE: src/rte_pkg.sv
// Package: types, constants and codes shared by the relay task executor.
`default_nettype none
package rte_pkg;

  localparam int unsigned NumChunks         = 16;
  localparam int unsigned ChunkPayloadBytes = 512;
  localparam int unsigned CfgIdxW           = 2;
  localparam int unsigned CfgDataW          = 32;
  localparam int unsigned FifoDepth         = 4;
  localparam int unsigned FifoPtrW          = 2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgDeadline  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgAuthDelay = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgWorkDelay = 2'd2;

  // Message kind words.
  localparam logic [31:0] KindRequest = 32'd1;
  localparam logic [31:0] KindData    = 32'd3;
  localparam logic [31:0] KindReject  = 32'd5;

  // Required lengths.
  localparam logic [15:0] LenRequest = 16'd256;
  localparam logic [15:0] LenData    = 16'(32 + ChunkPayloadBytes);
  localparam logic [15:0] LenOther   = 16'd64;

  typedef enum logic [1:0] {
    ReplyPermit  = 2'd0,
    ReplyReceipt = 2'd1,
    ReplyReject  = 2'd2
  } reply_kind_e;

  typedef struct packed {
    logic        action;
    logic        from_peer;
    logic [15:0] msg_length;
    logic [31:0] msg_kind;
    logic [31:0] msg_token;
    logic [31:0] msg_task;
    logic [31:0] msg_subject;
    logic [31:0] msg_audience;
    logic [31:0] msg_expires_ms;
    logic [31:0] msg_chunk;
    logic [31:0] msg_chunk_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  reply_kind;
    logic [31:0] reply_token;
    logic [31:0] reply_task;
    logic [31:0] reply_subject;
    logic [31:0] reply_audience;
    logic [31:0] reply_expires_ms;
    logic [31:0] reply_chunk;
    logic [31:0] reply_chunk_count;
    logic        delivered;
  } out_item_t;

  // Classified item passed from the front to the back part.
  typedef struct packed {
    logic     is_tick;
    logic     is_req;
    logic     is_data;
    logic     chunk_ok;
    logic     req_words_ok;
    in_item_t item;
  } cls_item_t;

endpackage
`default_nettype wire

FILE: src/rte_front.sv
// Front part: checks and classifies each input transfer, queues it for the back part.
`default_nettype none
module rte_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  output logic                   full_o,
  input  wire rte_pkg::in_item_t item_i,
  output logic                   cls_valid_o,
  input  wire logic              cls_take_i,
  output rte_pkg::cls_item_t     cls_o
);

  rte_pkg::cls_item_t           mem_q [rte_pkg::FifoDepth];
  logic [rte_pkg::FifoPtrW-1:0] wr_q, rd_q;
  logic [rte_pkg::FifoPtrW:0]   cnt_q;
  rte_pkg::cls_item_t           cls_d;
  logic                         wr_en, rd_en, len_ok, kind_ok;

  // Message screening: source, kind range, length and chunk count.
  always_comb begin
    kind_ok = (item_i.msg_kind >= rte_pkg::KindRequest) &&
              (item_i.msg_kind <= rte_pkg::KindReject);
    if (item_i.msg_kind == rte_pkg::KindData) begin
      len_ok = item_i.msg_length == rte_pkg::LenData;
    end else if (item_i.msg_kind == rte_pkg::KindRequest) begin
      len_ok = item_i.msg_length == rte_pkg::LenRequest;
    end else begin
      len_ok = item_i.msg_length == rte_pkg::LenOther;
    end
    cls_d              = '0;
    cls_d.item         = item_i;
    cls_d.is_tick      = !item_i.action;
    cls_d.is_req       = item_i.action && item_i.from_peer && kind_ok && len_ok &&
                         item_i.msg_chunk_count == 32'(rte_pkg::NumChunks) &&
                         item_i.msg_kind == rte_pkg::KindRequest;
    cls_d.is_data      = item_i.action && item_i.from_peer && kind_ok && len_ok &&
                         item_i.msg_chunk_count == 32'(rte_pkg::NumChunks) &&
                         item_i.msg_kind == rte_pkg::KindData;
    cls_d.chunk_ok     = item_i.msg_chunk < 32'(rte_pkg::NumChunks);
    cls_d.req_words_ok = item_i.msg_token == 32'd1 && item_i.msg_subject == 32'd1 &&
                         item_i.msg_audience == 32'd1;
  end

  assign full_o      = cnt_q == (rte_pkg::FifoPtrW+1)'(rte_pkg::FifoDepth);
  assign wr_en       = push_i && !full_o;
  assign cls_valid_o = cnt_q != '0;
  assign rd_en       = cls_take_i && cls_valid_o;
  assign cls_o       = mem_q[rd_q];

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_q] <= cls_d;
    end
  end

  // Queue pointers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_en) wr_q <= wr_q + 1'b1;
      if (rd_en) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (rte_pkg::FifoPtrW+1)'(wr_en) - (rte_pkg::FifoPtrW+1)'(rd_en);
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (rte_pkg::FifoPtrW+1)'(rte_pkg::FifoDepth)) else $error("queue overflow");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en && !rd_en |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count step");
  a_tick_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cls_valid_o |-> !(cls_o.is_tick && (cls_o.is_req || cls_o.is_data)))
    else $error("class overlap");
`endif

endmodule
`default_nettype wire

FILE: src/rte_back.sv
// Back part: task state, timers and reply register.
`default_nettype none
module rte_back (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [rte_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [rte_pkg::CfgDataW-1:0]    cfg_data_i,
  input  wire logic                            cls_valid_i,
  output logic                                 cls_take_o,
  input  wire rte_pkg::cls_item_t              cls_i,
  output logic                                 empty_o,
  input  wire logic                            pop_i,
  output rte_pkg::out_item_t                   reply_o
);

  logic [31:0] deadline_q, now_q, due_q, now_d, due_d;
  logic [15:0] auth_dly_q, work_dly_q;
  logic        adm_q, auth_q, proc_q, done_q, apend_q, wpend_q;
  logic        adm_d, auth_d, proc_d, done_d, apend_d, wpend_d;
  logic [rte_pkg::NumChunks-1:0] seen_q, seen_d;
  logic [31:0] b_tok_q, b_task_q, b_sub_q, b_aud_q, b_exp_q, b_chk_q, b_cnt_q;
  logic        bind_en;
  logic        out_v_q;
  rte_pkg::out_item_t out_q, res;
  logic        res_v, go, same, live;
  logic [32:0] sum;
  rte_pkg::in_item_t it;

  assign it         = cls_i.item;
  assign go         = cls_valid_i && (!out_v_q || pop_i);
  assign cls_take_o = go;
  assign empty_o    = !out_v_q;
  assign reply_o    = out_q;

  // One step of the exchange.
  always_comb begin
    now_d = now_q; due_d = due_q;
    adm_d = adm_q; auth_d = auth_q; proc_d = proc_q; done_d = done_q;
    apend_d = apend_q; wpend_d = wpend_q; seen_d = seen_q;
    bind_en = 1'b0; res_v = 1'b0; res = '0; sum = '0;
    same = it.msg_token == b_tok_q && it.msg_task == b_task_q &&
           it.msg_subject == b_sub_q && it.msg_audience == b_aud_q &&
           it.msg_expires_ms == b_exp_q && it.msg_chunk_count == b_cnt_q;
    live = now_q < deadline_q;
    res.reply_token = b_tok_q; res.reply_task = b_task_q; res.reply_subject = b_sub_q;
    res.reply_audience = b_aud_q; res.reply_expires_ms = b_exp_q;
    res.reply_chunk = b_chk_q; res.reply_chunk_count = b_cnt_q;
    if (cls_i.is_tick) begin
      if (now_q != '1) now_d = now_q + 32'd1;
    end else if (cls_i.is_req && live) begin
      if (!cls_i.req_words_ok || (adm_q && !same) || (!adm_q && now_q >= it.msg_expires_ms))
      begin
        res_v = 1'b1;
        res.reply_kind = rte_pkg::ReplyReject;
        res.reply_token = it.msg_token; res.reply_task = it.msg_task;
        res.reply_subject = it.msg_subject; res.reply_audience = it.msg_audience;
        res.reply_expires_ms = it.msg_expires_ms; res.reply_chunk = it.msg_chunk;
        res.reply_chunk_count = it.msg_chunk_count;
      end else if (done_q) begin
        res_v = 1'b1; res.reply_kind = rte_pkg::ReplyReceipt;
      end else if (auth_q) begin
        res_v = 1'b1; res.reply_kind = rte_pkg::ReplyPermit;
      end else if (!adm_q) begin
        bind_en = 1'b1; adm_d = 1'b1; apend_d = 1'b1;
        sum = {1'b0, now_q} + {17'd0, auth_dly_q};
        due_d = sum[32] ? '1 : sum[31:0];
        res.reply_token = it.msg_token; res.reply_task = it.msg_task;
        res.reply_subject = it.msg_subject; res.reply_audience = it.msg_audience;
        res.reply_expires_ms = it.msg_expires_ms; res.reply_chunk = it.msg_chunk;
        res.reply_chunk_count = it.msg_chunk_count;
      end
    end else if (cls_i.is_data && live && auth_q && same && cls_i.chunk_ok && !proc_q) begin
      seen_d = seen_q | (rte_pkg::NumChunks'(1) << it.msg_chunk[5:0]);
      if (&seen_d) begin
        proc_d = 1'b1; wpend_d = 1'b1;
        sum = {1'b0, now_q} + {17'd0, work_dly_q};
        due_d = sum[32] ? '1 : sum[31:0];
      end
    end
    // Due event, evaluated after the step's own update.
    if (!res_v && apend_d && now_d >= due_d) begin
      apend_d = 1'b0; res_v = 1'b1;
      if (now_d >= deadline_q || now_d >= res.reply_expires_ms) begin
        res.reply_kind = rte_pkg::ReplyReject;
      end else begin
        auth_d = 1'b1; res.reply_kind = rte_pkg::ReplyPermit;
      end
    end else if (!res_v && wpend_d && now_d >= due_d) begin
      wpend_d = 1'b0;
      if (now_d < deadline_q) begin
        done_d = 1'b1; res_v = 1'b1;
        res.reply_kind = rte_pkg::ReplyReceipt; res.delivered = 1'b1;
      end
    end
  end

  // Bound task words and reply payload.
  always_ff @(posedge clk_i) begin
    if (go && bind_en) begin
      b_tok_q <= it.msg_token; b_task_q <= it.msg_task; b_sub_q <= it.msg_subject;
      b_aud_q <= it.msg_audience; b_exp_q <= it.msg_expires_ms;
      b_chk_q <= it.msg_chunk; b_cnt_q <= it.msg_chunk_count;
    end
    if (go && res_v) out_q <= res;
  end

  // Control state and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadline_q <= 32'd19000; auth_dly_q <= 16'd1; work_dly_q <= 16'd5;
      now_q <= '0; due_q <= '0; seen_q <= '0;
      adm_q <= 1'b0; auth_q <= 1'b0; proc_q <= 1'b0; done_q <= 1'b0;
      apend_q <= 1'b0; wpend_q <= 1'b0; out_v_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          rte_pkg::CfgDeadline:  deadline_q <= cfg_data_i;
          rte_pkg::CfgAuthDelay: auth_dly_q <= cfg_data_i[15:0];
          rte_pkg::CfgWorkDelay: work_dly_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (go) begin
        now_q <= now_d; due_q <= due_d; seen_q <= seen_d;
        adm_q <= adm_d; auth_q <= auth_d; proc_q <= proc_d; done_q <= done_d;
        apend_q <= apend_d; wpend_q <= wpend_d;
      end
      if (go) out_v_q <= res_v;
      else if (pop_i) out_v_q <= 1'b0;
    end
  end

`ifndef SYNTH
  a_pend_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(apend_q && wpend_q)) else $error("both events pending");
  a_auth_adm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    auth_q |-> adm_q) else $error("authorized without admission");
  a_done_proc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> proc_q) else $error("done without processing");
  a_clock_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    now_q >= $past(now_q) || $past(!rst_ni)) else $error("clock went back");
`endif

endmodule
`default_nettype wire

FILE: src/relay_task_executor.sv
// Top level: relay task executor, front screening queue and back state machine.
//   channel  | direction | handshake          | payload
//   input    | in        | push_i / full_o    | item_i  (rte_pkg::in_item_t)
//   result   | out       | empty_o / pop_i    | reply_o (rte_pkg::out_item_t)
//   config   | in        | cfg_we_i           | cfg_idx_i, cfg_data_i
// One item per cycle sustained while the result side does not stall; the back part handles each item as it takes it.
// An input is first written into the queue, then its result is registered in the reply register.
// A four-entry queue between front and back absorbs result-side stalls.
// Reset is asynchronous and clears all control state and timers.
`default_nettype none
module relay_task_executor (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push_i,
  output logic                               full_o,
  input  wire rte_pkg::in_item_t             item_i,
  output logic                               empty_o,
  input  wire logic                          pop_i,
  output rte_pkg::out_item_t                 reply_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [rte_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [rte_pkg::CfgDataW-1:0]  cfg_data_i
);

  logic               cls_valid, cls_take;
  rte_pkg::cls_item_t cls;

  rte_front u_front (
    .clk_i, .rst_ni, .push_i, .full_o, .item_i,
    .cls_valid_o(cls_valid), .cls_take_i(cls_take), .cls_o(cls)
  );

  rte_back u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .cls_valid_i(cls_valid), .cls_take_o(cls_take), .cls_i(cls),
    .empty_o, .pop_i, .reply_o
  );

endmodule
`default_nettype wire
